### design/rgb_color_temperature_and_lux_unit_macros.svh
// ----------------------------------------------------------------------------
// RGB CCT and lux unit assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB_COLOR_TEMPERATURE_AND_LUX_UNIT_MACROS_SVH
`define RGB_COLOR_TEMPERATURE_AND_LUX_UNIT_MACROS_SVH

// same-cycle implication
`define RGBCT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RGBCT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/rgbct_pkg.sv
// ----------------------------------------------------------------------------
// RGB CCT and lux package
// Fixed-point formats, coefficients, status codes and item types.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbct_pkg;

	// fixed-point formats
	localparam int FRAC_BITS = 16;
	localparam int NQ        = 24;
	localparam int CF_W      = FRAC_BITS + 2;
	localparam int XYZ_W     = FRAC_BITS + 20;
	localparam int S_W       = FRAC_BITS + 22;
	localparam int ND_W      = FRAC_BITS + 23;
	localparam int N_W       = 32;

	localparam longint ONE = longint'(1) << FRAC_BITS;

	// matrix coefficients, rounded to nearest with ties away from zero
	localparam longint C_XR = -(((longint'(14282)  << FRAC_BITS) + 50000) / 100000);
	localparam longint C_XG =  (((longint'(154924) << FRAC_BITS) + 50000) / 100000);
	localparam longint C_XB = -(((longint'(95641)  << FRAC_BITS) + 50000) / 100000);
	localparam longint C_YR = -(((longint'(32466)  << FRAC_BITS) + 50000) / 100000);
	localparam longint C_YG =  (((longint'(157837) << FRAC_BITS) + 50000) / 100000);
	localparam longint C_YB = -(((longint'(73191)  << FRAC_BITS) + 50000) / 100000);
	localparam longint C_ZR = -(((longint'(68202)  << FRAC_BITS) + 50000) / 100000);
	localparam longint C_ZG =  (((longint'(77073)  << FRAC_BITS) + 50000) / 100000);
	localparam longint C_ZB =  (((longint'(56332)  << FRAC_BITS) + 50000) / 100000);

	localparam logic signed [CF_W-1:0] MAT [0:8] = '{
		CF_W'(C_XR), CF_W'(C_XG), CF_W'(C_XB),
		CF_W'(C_YR), CF_W'(C_YG), CF_W'(C_YB),
		CF_W'(C_ZR), CF_W'(C_ZG), CF_W'(C_ZB)
	};

	// McCamy constants
	localparam longint C_EPI = ((longint'(33200) << FRAC_BITS) + 50000) / 100000;
	localparam longint C_SLP = ((longint'(18580) << FRAC_BITS) + 50000) / 100000;
	localparam longint K_A3  = 449;
	localparam longint K_A2  = longint'(3525) << NQ;
	localparam longint K_A1  = (((longint'(68233) << FRAC_BITS) + 5) / 10)
		<< (NQ - FRAC_BITS);
	localparam longint K_A0  = (((longint'(552033) << FRAC_BITS) + 50) / 100)
		<< (NQ - FRAC_BITS);

	// lux limits on Y
	localparam longint LUX_NEG = 1 - ONE;
	localparam longint LUX_TOP = longint'(65536) << FRAC_BITS;

	// CCT status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DEGEN = 2'd1;
	localparam logic [1:0] ST_LOW   = 2'd2;
	localparam logic [1:0] ST_HIGH  = 2'd3;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} sample_t;

	typedef struct packed {
		logic [15:0] cct_kelvin;
		logic [1:0]  cct_status;
		logic [15:0] lux;
		logic        lux_clamped;
	} result_t;

	// values that ride along the pipeline
	typedef struct packed {
		logic        degen;
		logic [15:0] lux;
		logic        lux_clamped;
	} side_t;

	typedef struct packed {
		logic signed [ND_W-1:0] num;
		logic signed [ND_W-1:0] den;
		side_t                  side;
	} ratio_t;

	typedef struct packed {
		logic signed [N_W-1:0] n;
		side_t                 side;
	} index_t;

endpackage

`default_nettype wire

### design/rgbct_matrix.sv
// ----------------------------------------------------------------------------
// RGB CCT matrix front end
// Maps raw counts to X, Y, Z, derives lux and McCamy numerator and denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbct_matrix (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rgbct_pkg::sample_t in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output rgbct_pkg::ratio_t      out_item
);

	localparam int L    = 5;
	localparam int PR_W = rgbct_pkg::CF_W + 17;
	localparam int SA_W = rgbct_pkg::S_W + rgbct_pkg::CF_W;
	localparam int XW   = rgbct_pkg::XYZ_W;
	localparam int SW   = rgbct_pkg::S_W;
	localparam int DW   = rgbct_pkg::ND_W;
	localparam int F    = rgbct_pkg::FRAC_BITS;

	logic [L-1:0] v_q;
	logic [L-1:0] ld;
	logic [15:0]  ch [0:2];

	logic signed [PR_W-1:0] p_s1 [0:8];
	logic signed [XW-1:0]   xyz_s2 [0:2];
	logic signed [SW-1:0]   sum_s3;
	logic signed [XW-1:0]   x_s3, y_s3, x_s4, y_s4;
	rgbct_pkg::side_t       side_s3, side_s4;
	logic signed [SA_W-1:0] sa_s4, sb_s4;
	logic                   szero_s4;
	rgbct_pkg::ratio_t      rat_s5;
	logic signed [DW-1:0]   num_c, den_c;
	logic                   lux_lo_c, lux_hi_c;

	// advance a stage when it is empty or its successor advances
	always_comb begin
		ld[L-1] = !v_q[L-1] || out_ready;
		for (int k = L - 2; k >= 0; k--) begin
			ld[k] = !v_q[k] || ld[k+1];
		end
	end

	assign in_ready  = ld[0];
	assign out_valid = v_q[L-1];
	assign out_item  = rat_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (ld[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < L; k++) begin
				if (ld[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign ch[0] = in_item.red;
	assign ch[1] = in_item.green;
	assign ch[2] = in_item.blue;

	// stage 1: matrix products
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s1[i*3+j] <= PR_W'(rgbct_pkg::MAT[i*3+j]) * PR_W'($signed({1'b0, ch[j]}));
				end
			end
		end
	end

	// stage 2: row sums
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			for (int i = 0; i < 3; i++) begin
				xyz_s2[i] <= XW'(p_s1[i*3]) + XW'(p_s1[i*3+1]) + XW'(p_s1[i*3+2]);
			end
		end
	end

	// lux from Y, truncated toward zero
	assign lux_lo_c = xyz_s2[1] < XW'(rgbct_pkg::LUX_NEG);
	assign lux_hi_c = xyz_s2[1] >= XW'(rgbct_pkg::LUX_TOP);

	// stage 3: chromaticity sum and lux
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			sum_s3 <= SW'(xyz_s2[0]) + SW'(xyz_s2[1]) + SW'(xyz_s2[2]);
			x_s3   <= xyz_s2[0];
			y_s3   <= xyz_s2[1];
			side_s3.degen       <= 1'b0;
			side_s3.lux_clamped <= lux_lo_c || lux_hi_c;
			if (lux_hi_c) begin
				side_s3.lux <= 16'hFFFF;
			end else if (xyz_s2[1] < 0) begin
				side_s3.lux <= 16'h0000;
			end else begin
				side_s3.lux <= xyz_s2[1][F+15:F];
			end
		end
	end

	// stage 4: scale S by the epicenter coordinates
	always_ff @(posedge clk) begin
		if (ld[3]) begin
			sa_s4    <= SA_W'(sum_s3) * SA_W'(rgbct_pkg::C_EPI);
			sb_s4    <= SA_W'(sum_s3) * SA_W'(rgbct_pkg::C_SLP);
			szero_s4 <= sum_s3 == '0;
			x_s4     <= x_s3;
			y_s4     <= y_s3;
			side_s4  <= side_s3;
		end
	end

	assign num_c = DW'(x_s4) - DW'(sa_s4 >>> F);
	assign den_c = DW'(sb_s4 >>> F) - DW'(y_s4);

	// stage 5: numerator, denominator and degenerate flag
	always_ff @(posedge clk) begin
		if (ld[4]) begin
			rat_s5.num              <= num_c;
			rat_s5.den              <= den_c;
			rat_s5.side.lux         <= side_s4.lux;
			rat_s5.side.lux_clamped <= side_s4.lux_clamped;
			rat_s5.side.degen       <= szero_s4 || (den_c == '0);
		end
	end

endmodule

`default_nettype wire

### design/rgbct_div.sv
// ----------------------------------------------------------------------------
// RGB CCT pipelined divider
// Restoring division giving McCamy n as saturated signed Q8.24, two bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbct_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rgbct_pkg::ratio_t in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output rgbct_pkg::index_t      out_item
);

	localparam int DW    = rgbct_pkg::ND_W;
	localparam int QW    = rgbct_pkg::N_W - 1;
	localparam int STEPS = QW;
	localparam int BPS   = 2;
	localparam int NST   = (STEPS + BPS - 1) / BPS;
	localparam int IW    = QW - rgbct_pkg::NQ;
	localparam int L     = NST + 3;

	typedef struct packed {
		logic [DW-1:0]    r;
		logic [DW-1:0]    b;
		logic [QW-1:0]    q;
		logic [IW-1:0]    abits;
		logic             ovf;
		logic             neg;
		rgbct_pkg::side_t side;
	} dstep_t;

	logic [L-1:0]      v_q;
	logic [L-1:0]      ld;
	logic [DW-1:0]     a_s0, b_s0;
	logic              neg_s0;
	rgbct_pkg::side_t  side_s0;
	dstep_t            dv_s [0:NST];
	dstep_t            nxt_c [0:NST-1];
	rgbct_pkg::index_t n_s;
	logic [QW:0]       qf_c;

	// advance a stage when it is empty or its successor advances
	always_comb begin
		ld[L-1] = !v_q[L-1] || out_ready;
		for (int k = L - 2; k >= 0; k--) begin
			ld[k] = !v_q[k] || ld[k+1];
		end
	end

	assign in_ready  = ld[0];
	assign out_valid = v_q[L-1];
	assign out_item  = n_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (ld[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < L; k++) begin
				if (ld[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// entry: magnitudes and result sign
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			a_s0    <= in_item.num[DW-1] ? DW'(-in_item.num) : DW'(in_item.num);
			b_s0    <= in_item.den[DW-1] ? DW'(-in_item.den) : DW'(in_item.den);
			neg_s0  <= in_item.num[DW-1] ^ in_item.den[DW-1];
			side_s0 <= in_item.side;
		end
	end

	// setup: integer part of 128 or more saturates
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			dv_s[0].r     <= a_s0 >> IW;
			dv_s[0].b     <= b_s0;
			dv_s[0].q     <= '0;
			dv_s[0].abits <= a_s0[IW-1:0];
			dv_s[0].ovf   <= (a_s0 >> IW) >= b_s0;
			dv_s[0].neg   <= neg_s0;
			dv_s[0].side  <= side_s0;
		end
	end

	// quotient stages
	for (genvar g = 0; g < NST; g++) begin : g_step
		always_comb begin : step
			logic [DW:0] rr;
			logic        qb;
			nxt_c[g] = dv_s[g];
			for (int j = 0; j < BPS; j++) begin
				if (g * BPS + j < STEPS) begin
					rr = {nxt_c[g].r, nxt_c[g].abits[IW-1]};
					qb = 1'b0;
					if (rr >= {1'b0, nxt_c[g].b}) begin
						rr = rr - {1'b0, nxt_c[g].b};
						qb = 1'b1;
					end
					nxt_c[g].abits = {nxt_c[g].abits[IW-2:0], 1'b0};
					nxt_c[g].r     = rr[DW-1:0];
					nxt_c[g].q     = {nxt_c[g].q[QW-2:0], qb};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ld[g+2]) begin
				dv_s[g+1] <= nxt_c[g];
			end
		end
	end

	// saturate and apply sign
	always_comb begin
		if (dv_s[NST].ovf) begin
			qf_c = dv_s[NST].neg ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
		end else begin
			qf_c = {1'b0, dv_s[NST].q};
		end
	end

	always_ff @(posedge clk) begin
		if (ld[L-1]) begin
			n_s.n    <= dv_s[NST].neg ? $signed(-qf_c) : $signed(qf_c);
			n_s.side <= dv_s[NST].side;
		end
	end

endmodule

`default_nettype wire

### design/rgbct_cubic.sv
// ----------------------------------------------------------------------------
// RGB CCT cubic evaluator
// Horner evaluation of McCamy's cubic in Q.24 with split products, then clamp.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_color_temperature_and_lux_unit_macros.svh"

module rgbct_cubic (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rgbct_pkg::index_t in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output rgbct_pkg::result_t     out_item
);

	localparam int L     = 6;
	localparam int NW    = rgbct_pkg::N_W;
	localparam int NQ    = rgbct_pkg::NQ;
	localparam int LO_W  = 25;
	localparam int T1_W  = 43;
	localparam int T2_W  = 51;
	localparam int T3_W  = 59;
	localparam int H1_W  = T1_W - LO_W;
	localparam int H2_W  = T2_W - LO_W;
	localparam int PH1_W = H1_W + NW;
	localparam int PH2_W = H2_W + NW;
	localparam int PL_W  = LO_W + 1 + NW;
	localparam int F1_W  = T1_W + NW;
	localparam int F2_W  = T2_W + NW;
	localparam int V_W   = T3_W - NQ;

	logic [L-1:0] v_q;
	logic [L-1:0] ld;

	logic signed [T1_W-1:0]  t1_s1;
	logic signed [NW-1:0]    n_s1, n_s2, n_s3;
	logic signed [PH1_W-1:0] ph_s2;
	logic signed [PL_W-1:0]  pl_s2, pl_s4;
	logic signed [T2_W-1:0]  t2_s3;
	logic signed [PH2_W-1:0] ph_s4;
	logic signed [T3_W-1:0]  t3_s5;
	rgbct_pkg::side_t        side_s1, side_s2, side_s3, side_s4, side_s5;
	rgbct_pkg::result_t      res_s6;
	logic signed [F1_W-1:0]  f1_c;
	logic signed [F2_W-1:0]  f2_c;
	logic signed [V_W-1:0]   v_c;

	// advance a stage when it is empty or its successor advances
	always_comb begin
		ld[L-1] = !v_q[L-1] || out_ready;
		for (int k = L - 2; k >= 0; k--) begin
			ld[k] = !v_q[k] || ld[k+1];
		end
	end

	assign in_ready  = ld[0];
	assign out_valid = v_q[L-1];
	assign out_item  = res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (ld[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < L; k++) begin
				if (ld[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// stage 1: t = 449 n + 3525
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			t1_s1   <= T1_W'(in_item.n) * T1_W'(rgbct_pkg::K_A3) + T1_W'(rgbct_pkg::K_A2);
			n_s1    <= in_item.n;
			side_s1 <= in_item.side;
		end
	end

	// stage 2: partial products of t by n, signed high part and unsigned low part
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			ph_s2   <= PH1_W'($signed(t1_s1[T1_W-1:LO_W])) * PH1_W'(n_s1);
			pl_s2   <= PL_W'($signed({1'b0, t1_s1[LO_W-1:0]})) * PL_W'(n_s1);
			n_s2    <= n_s1;
			side_s2 <= side_s1;
		end
	end

	assign f1_c = (F1_W'(ph_s2) <<< LO_W) + F1_W'(pl_s2);

	// stage 3: floor shift and add the linear term
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			t2_s3   <= T2_W'(f1_c >>> NQ) + T2_W'(rgbct_pkg::K_A1);
			n_s3    <= n_s2;
			side_s3 <= side_s2;
		end
	end

	// stage 4: partial products of t by n, signed high part and unsigned low part
	always_ff @(posedge clk) begin
		if (ld[3]) begin
			ph_s4   <= PH2_W'($signed(t2_s3[T2_W-1:LO_W])) * PH2_W'(n_s3);
			pl_s4   <= PL_W'($signed({1'b0, t2_s3[LO_W-1:0]})) * PL_W'(n_s3);
			side_s4 <= side_s3;
		end
	end

	assign f2_c = (F2_W'(ph_s4) <<< LO_W) + F2_W'(pl_s4);

	// stage 5: floor shift and add the constant term
	always_ff @(posedge clk) begin
		if (ld[4]) begin
			t3_s5   <= T3_W'(f2_c >>> NQ) + T3_W'(rgbct_pkg::K_A0);
			side_s5 <= side_s4;
		end
	end

	// truncate toward zero
	assign v_c = V_W'(t3_s5 >>> NQ) + V_W'(t3_s5[T3_W-1] && (|t3_s5[NQ-1:0]));

	// stage 6: clamp and report
	always_ff @(posedge clk) begin
		if (ld[5]) begin
			res_s6.lux         <= side_s5.lux;
			res_s6.lux_clamped <= side_s5.lux_clamped;
			if (side_s5.degen) begin
				res_s6.cct_kelvin <= 16'h0000;
				res_s6.cct_status <= rgbct_pkg::ST_DEGEN;
			end else if (v_c < 0) begin
				res_s6.cct_kelvin <= 16'h0000;
				res_s6.cct_status <= rgbct_pkg::ST_LOW;
			end else if (v_c > V_W'(65535)) begin
				res_s6.cct_kelvin <= 16'hFFFF;
				res_s6.cct_status <= rgbct_pkg::ST_HIGH;
			end else begin
				res_s6.cct_kelvin <= v_c[15:0];
				res_s6.cct_status <= rgbct_pkg::ST_OK;
			end
		end
	end

	`RGBCT_ASSERT_IMP(a_degen_zero, v_q[L-1] && res_s6.cct_status == rgbct_pkg::ST_DEGEN, res_s6.cct_kelvin == 16'h0000, "degenerate cct")
	`RGBCT_ASSERT_IMP(a_high_sat, v_q[L-1] && res_s6.cct_status == rgbct_pkg::ST_HIGH, res_s6.cct_kelvin == 16'hFFFF, "high clamp")
	`RGBCT_ASSERT_NXT(a_stall_hold, v_q[2] && !ld[2], v_q[2], "stalled item dropped")

endmodule

`default_nettype wire

### design/rgb_color_temperature_and_lux_unit.sv
// ----------------------------------------------------------------------------
// RGB color temperature and lux unit
// Raw RGB counts in; McCamy correlated color temperature and lux out.
// ----------------------------------------------------------------------------
// One item per cycle sustained while the receiver is ready. The divider for n
// is a 31-step restoring divider (16 stages at two quotient bits each, plus
// entry, setup and output), with 5 stages of matrix work before it and 6 of
// cubic evaluation after it. Every stage holds its item under backpressure
// and empty stages close up, so input keeps flowing while a finished result
// waits. No configuration.
`default_nettype none

module rgb_color_temperature_and_lux_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sample_valid,
	output logic                    sample_ready,
	input  wire rgbct_pkg::sample_t sample,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output rgbct_pkg::result_t      result
);

	logic              mat_valid, mat_ready;
	rgbct_pkg::ratio_t mat_item;
	logic              div_valid, div_ready;
	rgbct_pkg::index_t div_item;

	// map counts to tristimulus, lux, numerator and denominator
	rgbct_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_valid),
		.in_ready  (sample_ready),
		.in_item   (sample),
		.out_valid (mat_valid),
		.out_ready (mat_ready),
		.out_item  (mat_item)
	);

	// divide for the McCamy index
	rgbct_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mat_valid),
		.in_ready  (mat_ready),
		.in_item   (mat_item),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_item  (div_item)
	);

	// evaluate the cubic and clamp
	rgbct_cubic u_cubic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_item   (div_item),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_item  (result)
	);

endmodule

`default_nettype wire

### dv/tb_rgb_color_temperature_and_lux_unit.sv
// ----------------------------------------------------------------------------
// RGB color temperature and lux unit testbench
// Drives raw RGB items through the valid/ready port and predicts the McCamy
// CCT, status, lux and lux clamp of each item in fixed point. Every result is
// checked in order against the oldest prediction, with and without sender
// gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rgb_color_temperature_and_lux_unit;

	localparam int FB = 16;
	localparam int QN = 24;

	logic               clk;
	logic               arst_n;
	logic               sample_valid;
	logic               sample_ready;
	rgbct_pkg::sample_t sample;
	logic               result_valid;
	logic               result_ready;
	rgbct_pkg::result_t result;

	rgbct_pkg::result_t expected_results[$];
	int      n_items;
	int      n_results;
	int      n_errors;
	int      n_degen;
	int      n_cct_low;
	int      n_cct_high;
	int      n_lux_clamp;
	int      gap_pct;
	int      stall_pct;

	rgb_color_temperature_and_lux_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #1 clk = ~clk;

	// round num/den to FB fraction bits, ties away from zero
	function automatic longint fixed_coef(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = ((mag << FB) + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint trunc_shift(longint v, int s);
		return (v >= 0) ? (v >>> s) : -((-v) >>> s);
	endfunction

	// floor(a*b / 2^s) without overflowing 64 bits
	function automatic longint mul_floor(longint a, longint b, int s);
		longint hi;
		longint lo;
		hi = floor_shift(a, s);
		lo = a - (hi << s);
		return hi * b + floor_shift(lo * b, s);
	endfunction

	// signed Q8.24 quotient, truncated toward zero and saturated
	function automatic longint index_q24(longint num, longint den);
		logic            neg;
		longint unsigned a;
		longint unsigned b;
		longint unsigned q;
		longint unsigned lim;
		neg = (num < 0) != (den < 0);
		a = (num < 0) ? -num : num;
		b = (den < 0) ? -den : den;
		lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
		if (a / b >= 128)
			q = lim;
		else begin
			q = (a << QN) / b;
			if (q > lim)
				q = lim;
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic rgbct_pkg::result_t predict_cct_lux(rgbct_pkg::sample_t s);
		longint  ch[3];
		longint  xyz[3];
		longint  coef[9];
		longint  sum;
		longint  num;
		longint  den;
		longint  n;
		longint  t;
		longint  v;
		longint  up;
		rgbct_pkg::result_t r;
		coef = '{-14282, 154924, -95641, -32466, 157837, -73191, -68202, 77073, 56332};
		up = longint'(1) << (QN - FB);
		ch[0] = s.red;
		ch[1] = s.green;
		ch[2] = s.blue;
		for (int i = 0; i < 3; i++) begin
			xyz[i] = 0;
			for (int j = 0; j < 3; j++)
				xyz[i] += fixed_coef(coef[i*3+j], 100000) * ch[j];
		end
		// lux from Y
		v = trunc_shift(xyz[1], FB);
		if (v < 0) begin
			r.lux = 16'h0000;
			r.lux_clamped = 1'b1;
		end else if (v > 65535) begin
			r.lux = 16'hFFFF;
			r.lux_clamped = 1'b1;
		end else begin
			r.lux = v[15:0];
			r.lux_clamped = 1'b0;
		end
		// McCamy cubic
		sum = xyz[0] + xyz[1] + xyz[2];
		num = xyz[0] - mul_floor(sum, fixed_coef(33200, 100000), FB);
		den = mul_floor(sum, fixed_coef(18580, 100000), FB) - xyz[1];
		if (sum == 0 || den == 0) begin
			r.cct_kelvin = 16'h0000;
			r.cct_status = rgbct_pkg::ST_DEGEN;
		end else begin
			n = index_q24(num, den);
			t = 449 * n + (longint'(3525) << QN);
			t = mul_floor(t, n, QN) + fixed_coef(68233, 10) * up;
			t = mul_floor(t, n, QN) + fixed_coef(552033, 100) * up;
			v = trunc_shift(t, QN);
			if (v < 0) begin
				r.cct_kelvin = 16'h0000;
				r.cct_status = rgbct_pkg::ST_LOW;
			end else if (v > 65535) begin
				r.cct_kelvin = 16'hFFFF;
				r.cct_status = rgbct_pkg::ST_HIGH;
			end else begin
				r.cct_kelvin = v[15:0];
				r.cct_status = rgbct_pkg::ST_OK;
			end
		end
		return r;
	endfunction

	// send one item, holding it until accepted
	task automatic send_rgb(logic [15:0] red, logic [15:0] green, logic [15:0] blue);
		rgbct_pkg::sample_t s;
		rgbct_pkg::result_t r;
		s.red = red;
		s.green = green;
		s.blue = blue;
		if ($urandom_range(99) < gap_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < gap_pct)
				@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (!sample_ready);
		r = predict_cct_lux(s);
		expected_results.push_back(r);
		n_items++;
		if (r.cct_status == rgbct_pkg::ST_DEGEN) n_degen++;
		if (r.cct_status == rgbct_pkg::ST_LOW) n_cct_low++;
		if (r.cct_status == rgbct_pkg::ST_HIGH) n_cct_high++;
		if (r.lux_clamped) n_lux_clamp++;
	endtask

	// extremes, single channels, degenerate and tiny counts
	task automatic test_directed();
		send_rgb(16'h0000, 16'h0000, 16'h0000);
		send_rgb(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_rgb(16'hFFFF, 16'h0000, 16'h0000);
		send_rgb(16'h0000, 16'hFFFF, 16'h0000);
		send_rgb(16'h0000, 16'h0000, 16'hFFFF);
		send_rgb(16'h0001, 16'h0000, 16'h0000);
		send_rgb(16'h0000, 16'h0001, 16'h0000);
		send_rgb(16'h0000, 16'h0000, 16'h0001);
		send_rgb(16'h0001, 16'h0001, 16'h0001);
		send_rgb(16'hAAAA, 16'h5555, 16'hAAAA);
		send_rgb(16'h5555, 16'hAAAA, 16'h5555);
		send_rgb(16'h8000, 16'h8000, 16'h8000);
		send_rgb(16'h0000, 16'hFFFF, 16'hFFFF);
		send_rgb(16'hFFFF, 16'hFFFF, 16'h0000);
		send_rgb(16'hFFFF, 16'h0000, 16'hFFFF);
		send_rgb(16'h7FFF, 16'hFFFF, 16'h0000);
		send_rgb(16'h1000, 16'h2000, 16'h0800);
		send_rgb(16'h0800, 16'h2000, 16'h1000);
		send_rgb(16'h0002, 16'h0000, 16'h0001);
		send_rgb(16'h3000, 16'h4000, 16'h2000);
	endtask

	// random counts: full range, small, near balanced light, and under a random cap
	task automatic test_random(int count, int gap, int stall);
		int          base;
		logic [15:0] c[3];
		gap_pct = gap;
		stall_pct = stall;
		repeat (count) begin
			case ($urandom_range(3))
				0: foreach (c[k]) c[k] = 16'($urandom);
				1: foreach (c[k]) c[k] = 16'($urandom_range(15));
				2: begin
					base = $urandom_range(60000);
					foreach (c[k]) c[k] = 16'(base + $urandom_range(5000) - 2500);
				end
				default: begin
					base = $urandom_range(65535);
					foreach (c[k]) c[k] = 16'($urandom_range(base));
				end
			endcase
			send_rgb(c[0], c[1], c[2]);
		end
	endtask

	// receiver stalls
	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= stall_pct);

	// check each result against the oldest prediction
	always @(posedge clk) begin
		rgbct_pkg::result_t e;
		if (arst_n && result_valid && result_ready) begin
			n_results++;
			if (expected_results.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("ERROR: unexpected result %h", result);
			end else begin
				e = expected_results.pop_front();
				if (result !== e) begin
					n_errors++;
					if (n_errors <= 10)
						$display("ERROR: rgb item %0d cct %0d/%0d st %0d/%0d lux %0d/%0d lc %0b/%0b",
							n_results, result.cct_kelvin, e.cct_kelvin, result.cct_status,
							e.cct_status, result.lux, e.lux, result.lux_clamped, e.lux_clamped);
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int wait_cycles;
		clk = 1'b0;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		result_ready = 1'b0;
		n_items = 0;
		n_results = 0;
		n_errors = 0;
		n_degen = 0;
		n_cct_low = 0;
		n_cct_high = 0;
		n_lux_clamp = 0;
		gap_pct = 0;
		stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(200, 6, 54);
		test_random(200, 54, 6);
		test_random(200, 0, 0);
		sample_valid <= 1'b0;
		// drain
		wait_cycles = 0;
		while (expected_results.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (40) @(posedge clk);
		if (expected_results.size() != 0) begin
			n_errors++;
			$display("ERROR: %0d results never arrived", expected_results.size());
		end
		$display("Sent %0d rgb items, checked %0d results, %0d mismatches.",
			n_items, n_results, n_errors);
		$display("Cases: degenerate %0d, cct low %0d, cct high %0d, lux clamped %0d.",
			n_degen, n_cct_low, n_cct_high, n_lux_clamp);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
